FILE: sv/setpoint_slew_generator_defines.svh
// Assertion macros for the setpoint slew generator.
`ifndef SETPOINT_SLEW_GENERATOR_DEFINES_SVH
`define SETPOINT_SLEW_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ssg_pkg.sv
// Shared types, constants and helpers for the setpoint slew generator.
package ssg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [2:0] CMD_COMMAND  = 3'd0;
  localparam logic [2:0] CMD_YAW_TICK = 3'd1;
  localparam logic [2:0] CMD_ALT_TICK = 3'd2;
  localparam logic [2:0] CMD_POS_TICK = 3'd3;
  localparam logic [2:0] CMD_ARM_SENT = 3'd4;

  localparam logic [31:0] CODE_ARM  = 32'd400;
  localparam logic [31:0] CODE_ALT  = 32'd178;
  localparam logic [31:0] CODE_YAW  = 32'd179;
  localparam logic [31:0] CODE_FWD  = 32'd180;
  localparam logic [31:0] CODE_STOP = 32'd181;
  localparam logic [31:0] CODE_GRIP = 32'd187;

  localparam logic [1:0] REG_INIT_ALT = 2'd0;
  localparam logic [1:0] REG_YAW_STEP = 2'd1;
  localparam logic [1:0] REG_ALT_STEP = 2'd2;
  localparam logic [1:0] REG_POS_STEP = 2'd3;

  localparam logic [1:0] GRIP_NONE    = 2'd0;
  localparam logic [1:0] GRIP_OPEN    = 2'd1;
  localparam logic [1:0] GRIP_CLOSE   = 2'd2;
  localparam logic [1:0] GRIP_NEUTRAL = 2'd3;

  localparam logic signed [31:0] Q_ONE       = 32'sd65536;
  localparam logic signed [31:0] Q_MINUS_ONE = -32'sd65536;
  localparam logic signed [35:0] HALF_METRE  = 36'sd32768;
  localparam logic [15:0] TURN_TWELFTH = 16'd5461;
  localparam logic [16:0] YAW_DEADBAND = 17'd104;
  localparam logic signed [32:0] LIN_DEADBAND = 33'sd655;
  localparam logic [33:0] LIN_DEADBAND_U = 34'd655;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  localparam logic signed [31:0] RST_INIT_ALT = 32'sd196608;
  localparam logic [14:0] RST_YAW_STEP = 15'd546;
  localparam logic [30:0] RST_ALT_STEP = 31'd6554;
  localparam logic [30:0] RST_POS_STEP = 31'd6554;
  localparam logic signed [31:0] RST_GOAL_Z = 32'sd196608;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        command_code;
    logic signed [31:0] param_one;
    logic signed [31:0] param_two;
  } item_t;

  typedef struct packed {
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
    logic signed [31:0] set_z;
    logic [15:0]        set_yaw;
    logic               motion_enabled;
    logic               offboard_request;
    logic               land_request;
    logic [1:0]         gripper_request;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/ssg_cordic.sv
// Iterative rotation-mode CORDIC: cosine and sine of a 16-bit heading, Q2.30.
module ssg_cordic #(
  parameter int CORDIC_STEPS = ssg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        heading,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  import ssg_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_DONE = 3'b100
  } cstate_t;

  cstate_t state;
  logic [IW-1:0] step;
  logic signed [33:0] x, y, xs, ys, nx, ny;
  logic signed [32:0] z, ang;
  logic flip;
  logic [15:0] hf;
  logic hflip;

  // left half-plane headings are folded by pi
  assign hflip = heading[15] ^ heading[14];
  assign hf    = hflip ? (heading ^ 16'h8000) : heading;
  assign xs    = x >>> step;
  assign ys    = y >>> step;
  assign ang   = $signed({1'b0, atan_val(5'(step))});
  assign nx    = -x;
  assign ny    = -y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            x     <= $signed({2'b00, CORDIC_GAIN});
            y     <= '0;
            z     <= $signed({hf[15], hf, 16'h0000});
            flip  <= hflip;
            step  <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z[32]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end
          step <= step + 1'b1;
          if (step == IW'(CORDIC_STEPS - 1)) state <= C_DONE;
        end
        C_DONE: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  assign done  = (state == C_DONE);
  assign cos_q = flip ? nx[31:0] : x[31:0];
  assign sin_q = flip ? ny[31:0] : y[31:0];

endmodule

FILE: sv/ssg_pos.sv
// Position step unit: distance by bit-serial square root, per-axis step by restoring divide.
module ssg_pos (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] cur_x,
  input  logic signed [31:0] cur_y,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic [30:0]        pos_step,
  output logic               done,
  output logic               upd,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y
);
  import ssg_pkg::*;

  typedef enum logic [10:0] {
    P_IDLE = 11'b00000000001,
    P_SQX  = 11'b00000000010,
    P_SQY  = 11'b00000000100,
    P_SUM  = 11'b00000001000,
    P_ROOT = 11'b00000010000,
    P_CHK  = 11'b00000100000,
    P_MUL  = 11'b00001000000,
    P_DLD  = 11'b00010000000,
    P_DIV  = 11'b00100000000,
    P_APP  = 11'b01000000000,
    P_DONE = 11'b10000000000
  } pstate_t;

  pstate_t state;
  logic signed [31:0] cx, cy, gx, gy;
  logic signed [32:0] ex, ey;
  logic [32:0] nex, ney;
  logic negx, negy, sh, axis;
  logic [31:0] ax, ay, mag;
  logic [30:0] bx, by;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [62:0] prod, acc, v, r, bitm, r_try;
  logic [33:0] span, dist_n, rem, num, q;
  logic [34:0] t;
  logic [5:0] cnt;
  logic signed [35:0] wide_cur, moved;

  assign ex  = $signed({goal_x[31], goal_x}) - $signed({cur_x[31], cur_x});
  assign ey  = $signed({goal_y[31], goal_y}) - $signed({cur_y[31], cur_y});
  assign nex = -ex;
  assign ney = -ey;

  assign bx = sh ? ax[31:1] : ax[30:0];
  assign by = sh ? ay[31:1] : ay[30:0];
  assign mag = axis ? ay : ax;

  // one shared multiplier for the squares and the step products
  always_comb begin
    unique case (state)
      P_SQX:   begin mul_a = {1'b0, bx}; mul_b = {1'b0, bx}; end
      P_SQY:   begin mul_a = {1'b0, by}; mul_b = {1'b0, by}; end
      default: begin mul_a = mag;        mul_b = {1'b0, pos_step}; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign r_try  = r + bitm;
  assign dist_n = sh ? {r[32:0], 1'b0} : {1'b0, r[32:0]};
  assign t      = {rem, num[33]};

  assign wide_cur = axis ? {{4{cy[31]}}, cy} : {{4{cx[31]}}, cx};
  assign moved = (axis ? negy : negx) ? (wide_cur - $signed({2'b00, q}))
                                      : (wide_cur + $signed({2'b00, q}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      upd   <= 1'b0;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (start) begin
            cx    <= cur_x;
            cy    <= cur_y;
            gx    <= goal_x;
            gy    <= goal_y;
            negx  <= ex[32];
            negy  <= ey[32];
            ax    <= ex[32] ? nex[31:0] : ex[31:0];
            ay    <= ey[32] ? ney[31:0] : ey[31:0];
            sh    <= (ex[32] ? nex[31] : ex[31]) | (ey[32] ? ney[31] : ey[31]);
            axis  <= 1'b0;
            upd   <= 1'b0;
            state <= P_SQX;
          end
        end
        P_SQX: begin
          prod  <= mul_p[62:0];
          state <= P_SQY;
        end
        P_SQY: begin
          acc   <= prod;
          prod  <= mul_p[62:0];
          state <= P_SUM;
        end
        P_SUM: begin
          v     <= acc + prod;
          r     <= '0;
          bitm  <= {1'b1, 62'd0};
          cnt   <= '0;
          state <= P_ROOT;
        end
        P_ROOT: begin
          if (v >= r_try) begin
            v <= v - r_try;
            r <= (r >> 1) + bitm;
          end else begin
            r <= r >> 1;
          end
          bitm <= bitm >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd31) state <= P_CHK;
        end
        P_CHK: begin
          span <= dist_n;
          if (dist_n <= LIN_DEADBAND_U) begin
            state <= P_DONE;
          end else if ({3'b000, pos_step} >= dist_n) begin
            new_x <= gx;
            new_y <= gy;
            upd   <= 1'b1;
            state <= P_DONE;
          end else begin
            state <= P_MUL;
          end
        end
        P_MUL: begin
          prod  <= mul_p[62:0];
          state <= P_DLD;
        end
        P_DLD: begin
          // quotient stays below 2^34, so the top bits are already below the distance
          rem   <= {5'd0, prod[62:34]};
          num   <= prod[33:0];
          q     <= '0;
          cnt   <= '0;
          state <= P_DIV;
        end
        P_DIV: begin
          if (t >= {1'b0, span}) begin
            rem <= 34'(t - {1'b0, span});
            q   <= {q[32:0], 1'b1};
          end else begin
            rem <= t[33:0];
            q   <= {q[32:0], 1'b0};
          end
          num <= {num[32:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd33) state <= P_APP;
        end
        P_APP: begin
          if (axis) begin
            new_y <= sat32(moved);
            upd   <= 1'b1;
            state <= P_DONE;
          end else begin
            new_x <= sat32(moved);
            axis  <= 1'b1;
            state <= P_MUL;
          end
        end
        P_DONE: state <= P_IDLE;
        default: state <= P_IDLE;
      endcase
    end
  end

  assign done = (state == P_DONE);

endmodule

FILE: sv/setpoint_slew_generator.sv
// Top level of the setpoint slew generator: command decode, slew ticks and sequencer.
// A result is offered once its item has been executed; a forward command first waits
// for the CORDIC iterations, and a position tick while motion is enabled waits for the
// position unit (32 root steps, then 34 divide steps per axis when it moves).
// One item at a time: the next transfer is taken the cycle after the result transfers.
// Reset (rst, synchronous) restores registers and setpoints to their defaults.
`include "setpoint_slew_generator_defines.svh"

module setpoint_slew_generator #(
  parameter int CORDIC_STEPS = ssg_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  ssg_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_stall,
  output ssg_pkg::res_t  res,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import ssg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_CORD = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_POS  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  item_t  itm;

  logic signed [31:0] init_alt;
  logic [14:0] yaw_step;
  logic [30:0] alt_step, pos_step;

  logic signed [31:0] cur_x, cur_y, cur_z, goal_x, goal_y, goal_z;
  logic [15:0] cur_heading, goal_heading;
  logic enable_flag, arm_pending;
  logic off_req, land_req;
  logic [1:0] grip_req;

  logic signed [31:0] cs, sn, mul_b;
  logic signed [63:0] prod, mul_p, rnd;
  logic axis;

  logic cord_start, cord_done, pos_start, pos_done, pos_upd;
  logic signed [31:0] cord_c, cord_s, pos_x, pos_y;

  logic [15:0] hd;
  logic [16:0] hmag;
  logic signed [32:0] ez;
  logic signed [35:0] acc_sum;

  assign cord_start = (state == S_EXEC) && (itm.cmd == CMD_COMMAND)
                      && (itm.command_code == CODE_FWD);
  assign pos_start  = (state == S_EXEC) && (itm.cmd == CMD_POS_TICK) && enable_flag;

  ssg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .heading (cur_heading),
    .done    (cord_done),
    .cos_q   (cord_c),
    .sin_q   (cord_s)
  );

  ssg_pos u_pos (
    .clk      (clk),
    .rst      (rst),
    .start    (pos_start),
    .cur_x    (cur_x),
    .cur_y    (cur_y),
    .goal_x   (goal_x),
    .goal_y   (goal_y),
    .pos_step (pos_step),
    .done     (pos_done),
    .upd      (pos_upd),
    .new_x    (pos_x),
    .new_y    (pos_y)
  );

  // heading error as a signed 16-bit wrap, magnitude in 17 bits
  assign hd   = goal_heading - cur_heading;
  assign hmag = hd[15] ? (17'h10000 - {1'b0, hd}) : {1'b0, hd};
  assign ez   = $signed({goal_z[31], goal_z}) - $signed({cur_z[31], cur_z});

  assign mul_b   = axis ? sn : cs;
  assign mul_p   = itm.param_one * mul_b;
  assign rnd     = (prod + 64'sd536870912) >>> 30;
  assign acc_sum = (axis ? {{4{goal_y[31]}}, goal_y} : {{4{goal_x[31]}}, goal_x})
                   + rnd[35:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      init_alt     <= RST_INIT_ALT;
      yaw_step     <= RST_YAW_STEP;
      alt_step     <= RST_ALT_STEP;
      pos_step     <= RST_POS_STEP;
      cur_x        <= '0;
      cur_y        <= '0;
      cur_z        <= '0;
      goal_x       <= '0;
      goal_y       <= '0;
      goal_z       <= RST_GOAL_Z;
      cur_heading  <= '0;
      goal_heading <= '0;
      enable_flag  <= 1'b0;
      arm_pending  <= 1'b0;
      off_req      <= 1'b0;
      land_req     <= 1'b0;
      grip_req     <= GRIP_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INIT_ALT: init_alt <= cfg_data;
          REG_YAW_STEP: yaw_step <= cfg_data[14:0];
          REG_ALT_STEP: alt_step <= cfg_data[30:0];
          REG_POS_STEP: pos_step <= cfg_data[30:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            itm      <= item;
            off_req  <= 1'b0;
            land_req <= 1'b0;
            grip_req <= GRIP_NONE;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          if (itm.cmd == CMD_COMMAND) begin
            if (itm.command_code == CODE_ARM) begin
              if (itm.param_one == Q_ONE) begin
                arm_pending <= 1'b1;
                goal_z      <= init_alt;
                goal_x      <= cur_x;
                goal_y      <= cur_y;
                off_req     <= 1'b1;
              end else if (itm.param_one == '0) begin
                enable_flag <= 1'b0;
                land_req    <= 1'b1;
              end
            end else if (itm.command_code == CODE_ALT) begin
              if (itm.param_two == Q_MINUS_ONE)
                goal_z <= sat32({{4{goal_z[31]}}, goal_z} + HALF_METRE);
              else if (itm.param_two == Q_ONE)
                goal_z <= sat32({{4{goal_z[31]}}, goal_z} - HALF_METRE);
            end else if (itm.command_code == CODE_YAW) begin
              if (itm.param_one == Q_MINUS_ONE) goal_heading <= cur_heading + TURN_TWELFTH;
              else if (itm.param_one == Q_ONE) goal_heading <= cur_heading - TURN_TWELFTH;
            end else if (itm.command_code == CODE_STOP) begin
              goal_x       <= cur_x;
              goal_y       <= cur_y;
              goal_z       <= cur_z;
              goal_heading <= cur_heading;
            end else if (itm.command_code == CODE_FWD) begin
              state <= S_CORD;
            end else if (itm.command_code == CODE_GRIP) begin
              if (itm.param_one == Q_ONE && itm.param_two == Q_ONE)
                grip_req <= GRIP_OPEN;
              else if (itm.param_one == Q_MINUS_ONE && itm.param_two == Q_MINUS_ONE)
                grip_req <= GRIP_CLOSE;
              else
                grip_req <= GRIP_NEUTRAL;
            end
          end else if (itm.cmd == CMD_ARM_SENT) begin
            if (arm_pending) begin
              enable_flag <= 1'b1;
              arm_pending <= 1'b0;
            end
          end else if (enable_flag) begin
            if (itm.cmd == CMD_YAW_TICK) begin
              if (hmag > YAW_DEADBAND) begin
                if (hmag < {2'b00, yaw_step}) cur_heading <= goal_heading;
                else if (!hd[15]) cur_heading <= cur_heading + {1'b0, yaw_step};
                else cur_heading <= cur_heading - {1'b0, yaw_step};
              end
            end else if (itm.cmd == CMD_ALT_TICK) begin
              // no snap: the altitude may overshoot by less than one step
              if (ez > LIN_DEADBAND)
                cur_z <= sat32({{4{cur_z[31]}}, cur_z} + $signed({5'd0, alt_step}));
              else if (ez < -LIN_DEADBAND)
                cur_z <= sat32({{4{cur_z[31]}}, cur_z} - $signed({5'd0, alt_step}));
            end else if (itm.cmd == CMD_POS_TICK) begin
              state <= S_POS;
            end
          end
        end
        S_CORD: begin
          if (cord_done) begin
            cs    <= cord_c;
            sn    <= cord_s;
            axis  <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          if (axis) begin
            goal_y <= sat32(acc_sum);
            state  <= S_OUT;
          end else begin
            goal_x <= sat32(acc_sum);
            axis   <= 1'b1;
            state  <= S_MUL;
          end
        end
        S_POS: begin
          if (pos_done) begin
            if (pos_upd) begin
              cur_x <= pos_x;
              cur_y <= pos_y;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_stall = (state != S_IDLE);
  assign res_valid  = (state == S_OUT);

  always_comb begin
    res.set_x            = cur_x;
    res.set_y            = cur_y;
    res.set_z            = cur_z;
    res.set_yaw          = cur_heading;
    res.motion_enabled   = enable_flag;
    res.offboard_request = off_req;
    res.land_request     = land_req;
    res.gripper_request  = grip_req;
  end

  `SSG_ASSERT_NEXT(a_take_exec, item_valid && !item_stall, state == S_EXEC, "transfer not decoded")
  `SSG_ASSERT_IMPL(a_en_armed, $rose(enable_flag), $past(arm_pending), "enabled without arm")
  `SSG_ASSERT_IMPL(a_pos_wait, pos_done, state == S_POS, "position unit done out of sequence")
  `SSG_ASSERT_IMPL(a_cord_wait, cord_done, state == S_CORD, "CORDIC done out of sequence")

endmodule
